// ===== hw/rtl/stereo_width_ramped_core_defines.svh =====
// stereo_width_ramped_core_defines.svh
// Assertion macros for the stereo width core; included by the top level only.
// Expands to nothing when SYNTHESIS is defined.
`ifndef STEREO_WIDTH_RAMPED_CORE_DEFINES_SVH
`define STEREO_WIDTH_RAMPED_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define SWR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("swr: same-cycle check failed");
// Next-cycle implication, disabled during reset.
`define SWR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("swr: next-cycle check failed");
`else
`define SWR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define SWR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/swr_pkg.sv =====
// swr_pkg.sv
// Shared constants, types and helper functions of the stereo width core.
// No dependencies; compile first.
package swr_pkg;

  localparam int unsigned SAMPLE_BITS = 24;
  localparam int unsigned MAX_BLOCK   = 4096;
  localparam int unsigned CNT_W       = 13;

  localparam logic [30:0] ONE_Q30       = 31'h4000_0000;
  localparam logic [16:0] DRY_WET_RESET = 17'd65536;
  localparam logic [15:0] WIDTH_RESET   = 16'd32768;
  localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_BLOCK);

  // Register index (APB byte address bit 2)
  localparam logic REG_DRY_WET = 1'b0;
  localparam logic REG_WIDTH   = 1'b1;

  // Item kinds
  localparam logic CMD_PREPARE = 1'b0;
  localparam logic CMD_FRAME   = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_P_SETUP,
    ST_P_MUL,
    ST_P_ACC,
    ST_P_SHIFT,
    ST_P_DIVM,
    ST_P_DIVG,
    ST_F_MUL_SIDE,
    ST_F_WIDE,
    ST_F_MUL_L,
    ST_F_MUL_R,
    ST_F_OUT
  } swr_state_e;

  typedef struct packed {
    logic              start;
    logic signed [31:0] num;
    logic [CNT_W-1:0]  den;
  } swr_div_req_t;

  typedef struct packed {
    logic              done;
    logic signed [31:0] quo;
  } swr_div_rsp_t;

  // 2^(2^-(i+1)) in Q30, rounded
  function automatic logic [30:0] exp2_frac(input logic [3:0] idx);
    logic [30:0] v;
    case (idx)
      4'd0:    v = 31'd1518500250;
      4'd1:    v = 31'd1276901417;
      4'd2:    v = 31'd1170923762;
      4'd3:    v = 31'd1121280436;
      4'd4:    v = 31'd1097253708;
      4'd5:    v = 31'd1085434106;
      4'd6:    v = 31'd1079572136;
      4'd7:    v = 31'd1076653033;
      4'd8:    v = 31'd1075196443;
      4'd9:    v = 31'd1074468888;
      4'd10:   v = 31'd1074105294;
      4'd11:   v = 31'd1073923544;
      4'd12:   v = 31'd1073832680;
      4'd13:   v = 31'd1073787251;
      4'd14:   v = 31'd1073764537;
      4'd15:   v = 31'd1073753181;
      default: v = 31'd1073741824;
    endcase
    return v;
  endfunction

  // Saturate a rounded sample to SAMPLE_BITS signed bits
  function automatic logic [SAMPLE_BITS-1:0] sat_sample(input logic signed [46:0] v);
    logic signed [46:0] smax;
    logic signed [46:0] smin;
    logic [SAMPLE_BITS-1:0] res;
    smax = 47'sd1 <<< (SAMPLE_BITS - 1);
    smax = smax - 47'sd1;
    smin = -smax - 47'sd1;
    if (v > smax) begin
      res = smax[SAMPLE_BITS-1:0];
    end else if (v < smin) begin
      res = smin[SAMPLE_BITS-1:0];
    end else begin
      res = v[SAMPLE_BITS-1:0];
    end
    return res;
  endfunction

  // Hold a ramp value within 0..1.0 (Q30)
  function automatic logic [30:0] clamp_ramp(input logic signed [32:0] v);
    logic [30:0] res;
    if (v < 33'sd0) begin
      res = '0;
    end else if (v > $signed({2'b00, ONE_Q30})) begin
      res = ONE_Q30;
    end else begin
      res = v[30:0];
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/swr_if.sv =====
// swr_if.sv
// Valid/ready stream interfaces for input items and result items.
// Depends on swr_pkg for the sample width.
interface swr_in_if import swr_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;
  logic [CNT_W-1:0]              num_frames;
  logic signed [17:0]            dry_wet_mod;
  logic signed [18:0]            width_mod;

  modport source (output valid, command, left_in, right_in, num_frames, dry_wet_mod,
                  width_mod, input ready);
  modport sink (input valid, command, left_in, right_in, num_frames, dry_wet_mod,
                width_mod, output ready);
endinterface

interface swr_out_if import swr_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;

  modport source (output valid, left_out, right_out, input ready);
  modport sink (input valid, left_out, right_out, output ready);
endinterface

// ===== hw/rtl/stereo_width_ramped_core.sv =====
// stereo_width_ramped_core.sv
// Top level: sequencer, ramp state, APB registers and result register.
// Depends on swr_pkg, swr_if, swr_mul, swr_div and the assertion header.
//
// Mid/side stereo width with a dry/wet blend, both ramped linearly over a
// block of frames. A prepare beat (command 0) computes a dry/wet target
// clamped to 0..1 and a width gain 2^(3x), x saturated to -1..1, and sets per
// frame increments (target - current) / num_frames, or loads the targets at
// once when num_frames is zero (counts above 4096 act as 4096). A frame beat
// (command 1) returns one left/right result beat, saturated to 24 bits, and
// then advances both ramps, which saturate to 0..2^30 (mix 1.0, gain 8.0).
// One item is worked at a time and in_i.ready is high only while the
// sequencer is idle. A frame beat passes through F_MUL_SIDE, F_WIDE, F_MUL_L,
// F_MUL_R and F_OUT: three passes through the shared 32x32 multiplier (side
// gain, left blend, right blend). A prepare beat makes 16 multiplier passes
// (P_MUL, P_ACC) for the 2^x product, then, unless num_frames is zero, two
// 32-step quotients from the serial divider. The result register lets the
// next beat be accepted while a result still waits; a frame stalls in its
// last cycle only if the previous result has not been taken. Configuration
// through APB: dry_wet_setting at byte 0x0, width_setting at byte 0x4, write
// only while the block is idle.
`include "stereo_width_ramped_core_defines.svh"
module stereo_width_ramped_core import swr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  swr_in_if.sink      in_i,
  swr_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [16:0] dry_wet_q, dry_wet_d;
  logic [15:0] width_q, width_d;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    dry_wet_d = dry_wet_q;
    width_d   = width_q;
    if (cfg_wr) begin
      case (paddr[2])
        REG_DRY_WET: dry_wet_d = pwdata[16:0];
        REG_WIDTH:   width_d   = pwdata[15:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_DRY_WET: prdata = {15'd0, dry_wet_q};
      REG_WIDTH:   prdata = {16'd0, width_q};
      default:     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // State and datapath registers
  // ---------------------------------------------------------------------------
  swr_state_e state_q, state_d;

  // ramp state: mix and gain in Q30 / Q27, both held within 0..2^30
  logic [30:0]        mix_now_q, mix_now_d;
  logic [30:0]        gain_now_q, gain_now_d;
  logic signed [31:0] mix_step_q, mix_step_d;
  logic signed [31:0] gain_step_q, gain_step_d;

  // captured beat
  logic signed [SAMPLE_BITS-1:0] l_q, l_d;
  logic signed [SAMPLE_BITS-1:0] r_q, r_d;
  logic [CNT_W-1:0]              nf_q, nf_d;
  logic signed [17:0]            dwm_q, dwm_d;
  logic signed [18:0]            wm_q, wm_d;

  // prepare work registers
  logic [CNT_W-1:0] count_q, count_d;
  logic [30:0]      mix_t_q, mix_t_d;
  logic [30:0]      gain_t_q, gain_t_d;
  logic [15:0]      f_q, f_d;
  logic [2:0]       ish_q, ish_d;
  logic [30:0]      acc_q, acc_d;
  logic [3:0]       j_q, j_d;

  // frame work registers
  logic signed [31:0]            el_q, el_d;
  logic signed [31:0]            er_q, er_d;
  logic [SAMPLE_BITS-1:0]        ol_q, ol_d;

  // result register
  logic                          out_valid_q, out_valid_d;
  logic [SAMPLE_BITS-1:0]        out_l_q, out_l_d;
  logic [SAMPLE_BITS-1:0]        out_r_q, out_r_d;

  // ---------------------------------------------------------------------------
  // Shared units
  // ---------------------------------------------------------------------------
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  swr_div_req_t       div_req;
  swr_div_rsp_t       div_rsp;

  swr_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  swr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // ---------------------------------------------------------------------------
  // Combinational datapath pieces
  // ---------------------------------------------------------------------------
  logic               accept;
  logic               out_free;
  logic               finish;

  logic signed [18:0] dw_sum;
  logic [16:0]        dw_clamp;
  logic signed [19:0] wdev, x_raw, x_c, u_w;
  logic [CNT_W-1:0]   count_c;
  logic signed [63:0] exp_rnd;
  logic [30:0]        gain_t_c;
  logic signed [31:0] mix_diff, gain_diff;

  logic signed [24:0] side_d, sum_s, l2, r2;
  logic signed [63:0] side_sum;
  logic signed [29:0] pside;
  logic signed [63:0] ol_acc, or_acc;
  logic [SAMPLE_BITS-1:0] or_c;
  logic [27:0]        g24;
  logic [16:0]        m16;

  // take a new beat only while the sequencer is idle
  assign in_i.ready = (state_q == ST_IDLE);

  assign accept   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign finish   = (state_q == ST_F_OUT) && out_free;

  // dry/wet target: clamp base + offset to 0..1.0 (Q16)
  assign dw_sum = $signed({2'b00, dry_wet_q}) + 19'(dwm_q);
  always_comb begin
    if (dw_sum < 19'sd0) begin
      dw_clamp = '0;
    end else if (dw_sum > 19'sd65536) begin
      dw_clamp = 17'd65536;
    end else begin
      dw_clamp = dw_sum[16:0];
    end
  end

  // width exponent: x = 2*(knob - 1/2) + offset, saturated to -1..1, u = 3x + 3
  assign wdev  = $signed({4'd0, width_q}) - 20'sd32768;
  assign x_raw = (wdev <<< 1) + 20'(wm_q);
  always_comb begin
    if (x_raw < -20'sd65536) begin
      x_c = -20'sd65536;
    end else if (x_raw > 20'sd65536) begin
      x_c = 20'sd65536;
    end else begin
      x_c = x_raw;
    end
  end
  assign u_w = x_c + (x_c <<< 1) + 20'sd196608;

  assign count_c = (nf_q > MAX_COUNT) ? MAX_COUNT : nf_q;

  // round the running 2^f product back to Q30
  assign exp_rnd  = prod + 64'sd536870912;
  assign gain_t_c = acc_q >> (3'd6 - ish_q);

  assign mix_diff  = $signed({1'b0, mix_t_q}) - $signed({1'b0, mix_now_q});
  assign gain_diff = $signed({1'b0, gain_t_q}) - $signed({1'b0, gain_now_q});

  // frame: side = (L - R) * g, wet = (L + R) +/- side, blend toward dry
  assign g24      = gain_now_q[30:3];
  assign m16      = mix_now_q[30:14];
  assign side_d   = 25'(l_q) - 25'(r_q);
  assign sum_s    = 25'(l_q) + 25'(r_q);
  assign l2       = {l_q, 1'b0};
  assign r2       = {r_q, 1'b0};
  assign side_sum = prod + 64'sd8388608;
  assign pside    = side_sum[53:24];
  assign ol_acc   = (64'(l_q) <<< 17) + prod + 64'sd65536;
  assign or_acc   = (64'(r_q) <<< 17) + prod + 64'sd65536;
  assign or_c     = sat_sample(or_acc[63:17]);

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (in_i.command == CMD_FRAME) ? ST_F_MUL_SIDE : ST_P_SETUP;
        end
      end
      ST_P_SETUP:    state_d = ST_P_MUL;
      ST_P_MUL:      state_d = ST_P_ACC;
      ST_P_ACC:      state_d = (j_q == 4'd15) ? ST_P_SHIFT : ST_P_MUL;
      ST_P_SHIFT:    state_d = (count_q == '0) ? ST_IDLE : ST_P_DIVM;
      ST_P_DIVM:     state_d = div_rsp.done ? ST_P_DIVG : ST_P_DIVM;
      ST_P_DIVG:     state_d = div_rsp.done ? ST_IDLE : ST_P_DIVG;
      ST_F_MUL_SIDE: state_d = ST_F_WIDE;
      ST_F_WIDE:     state_d = ST_F_MUL_L;
      ST_F_MUL_L:    state_d = ST_F_MUL_R;
      ST_F_MUL_R:    state_d = ST_F_OUT;
      ST_F_OUT:      state_d = out_free ? ST_IDLE : ST_F_OUT;
      default:       state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Outputs and datapath updates
  // ---------------------------------------------------------------------------
  always_comb begin
    l_d   = l_q;
    r_d   = r_q;
    nf_d  = nf_q;
    dwm_d = dwm_q;
    wm_d  = wm_q;
    if (accept) begin
      l_d   = in_i.left_in;
      r_d   = in_i.right_in;
      nf_d  = in_i.num_frames;
      dwm_d = in_i.dry_wet_mod;
      wm_d  = in_i.width_mod;
    end

    count_d     = count_q;
    mix_t_d     = mix_t_q;
    gain_t_d    = gain_t_q;
    f_d         = f_q;
    ish_d       = ish_q;
    acc_d       = acc_q;
    j_d         = j_q;
    el_d        = el_q;
    er_d        = er_q;
    ol_d        = ol_q;
    mix_now_d   = mix_now_q;
    gain_now_d  = gain_now_q;
    mix_step_d  = mix_step_q;
    gain_step_d = gain_step_q;
    mul_a       = '0;
    mul_b       = '0;
    div_req     = '{start: 1'b0, num: mix_diff, den: count_q};

    case (state_q)
      ST_P_SETUP: begin
        count_d = count_c;
        mix_t_d = {dw_clamp, 14'd0};
        f_d     = u_w[15:0];
        ish_d   = u_w[18:16];
        acc_d   = ONE_Q30;
        j_d     = '0;
      end
      ST_P_MUL: begin
        mul_a = $signed({1'b0, acc_q});
        mul_b = $signed({1'b0, exp2_frac(j_q)});
      end
      ST_P_ACC: begin
        // fold in 2^(2^-(j+1)) when that fraction bit is set, MSB first
        if (f_q[~j_q]) begin
          acc_d = exp_rnd[60:30];
        end
        j_d = j_q + 4'd1;
      end
      ST_P_SHIFT: begin
        gain_t_d = gain_t_c;
        if (count_q == '0) begin
          mix_now_d   = mix_t_q;
          gain_now_d  = gain_t_c;
          mix_step_d  = '0;
          gain_step_d = '0;
        end else begin
          div_req.start = 1'b1;
        end
      end
      ST_P_DIVM: begin
        div_req.num = gain_diff;
        if (div_rsp.done) begin
          mix_step_d    = div_rsp.quo;
          div_req.start = 1'b1;
        end
      end
      ST_P_DIVG: begin
        if (div_rsp.done) begin
          gain_step_d = div_rsp.quo;
        end
      end
      ST_F_MUL_SIDE: begin
        mul_a = 32'(side_d);
        mul_b = $signed({4'd0, g24});
      end
      ST_F_WIDE: begin
        // excess of each wet channel over the dry one
        el_d = 32'(sum_s) + 32'(pside) - 32'(l2);
        er_d = 32'(sum_s) - 32'(pside) - 32'(r2);
      end
      ST_F_MUL_L: begin
        mul_a = el_q;
        mul_b = $signed({15'd0, m16});
      end
      ST_F_MUL_R: begin
        ol_d  = sat_sample(ol_acc[63:17]);
        mul_a = er_q;
        mul_b = $signed({15'd0, m16});
      end
      ST_F_OUT: begin
        // hold the right product until the result register frees up
        mul_a = er_q;
        mul_b = $signed({15'd0, m16});
        if (out_free) begin
          mix_now_d  = clamp_ramp($signed({2'b00, mix_now_q}) + 33'(mix_step_q));
          gain_now_d = clamp_ramp($signed({2'b00, gain_now_q}) + 33'(gain_step_q));
        end
      end
      default: ;
    endcase

    out_valid_d = out_valid_q;
    out_l_d     = out_l_q;
    out_r_d     = out_r_q;
    if (finish) begin
      out_valid_d = 1'b1;
      out_l_d     = ol_q;
      out_r_d     = or_c;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.left_out  = $signed(out_l_q);
  assign out_o.right_out = $signed(out_r_q);

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      dry_wet_q   <= DRY_WET_RESET;
      width_q     <= WIDTH_RESET;
      mix_now_q   <= '0;
      gain_now_q  <= '0;
      mix_step_q  <= '0;
      gain_step_q <= '0;
      out_valid_q <= 1'b0;
      j_q         <= '0;
    end else begin
      state_q     <= state_d;
      dry_wet_q   <= dry_wet_d;
      width_q     <= width_d;
      mix_now_q   <= mix_now_d;
      gain_now_q  <= gain_now_d;
      mix_step_q  <= mix_step_d;
      gain_step_q <= gain_step_d;
      out_valid_q <= out_valid_d;
      j_q         <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    l_q      <= l_d;
    r_q      <= r_d;
    nf_q     <= nf_d;
    dwm_q    <= dwm_d;
    wm_q     <= wm_d;
    count_q  <= count_d;
    mix_t_q  <= mix_t_d;
    gain_t_q <= gain_t_d;
    f_q      <= f_d;
    ish_q    <= ish_d;
    acc_q    <= acc_d;
    el_q     <= el_d;
    er_q     <= er_d;
    ol_q     <= ol_d;
    out_l_q  <= out_l_d;
    out_r_q  <= out_r_d;
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `SWR_ASSERT_IMPL(a_mix_range, clk_i, rst_ni, 1'b1, mix_now_q <= ONE_Q30)
  `SWR_ASSERT_IMPL(a_gain_range, clk_i, rst_ni, 1'b1, gain_now_q <= ONE_Q30)
  `SWR_ASSERT_IMPL(a_div_done_in_prep, clk_i, rst_ni, div_rsp.done, (state_q == ST_P_DIVM) || (state_q == ST_P_DIVG))
  `SWR_ASSERT_NEXT(a_finish_loads_result, clk_i, rst_ni, finish, out_valid_q && (state_q == ST_IDLE))

endmodule

// ===== hw/rtl/swr_mul.sv =====
// swr_mul.sv
// Shared 32x32 signed multiplier with a registered product.
// No package dependencies.
module swr_mul (
  input  logic               clk_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic signed [63:0] p_o
);

  logic signed [63:0] p_q;
  logic signed [63:0] p_d;

  assign p_d = 64'(a_i) * 64'(b_i);

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

// ===== hw/rtl/swr_div.sv =====
// swr_div.sv
// Radix-2 restoring divider, signed dividend by unsigned count, truncating.
// Depends on swr_pkg (request/response structs); 32 steps per quotient.
module swr_div import swr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  swr_div_req_t req_i,
  output swr_div_rsp_t rsp_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [4:0]        cnt_q, cnt_d;
  logic [31:0]       mag_q, mag_d;
  logic [CNT_W-2:0]  rem_q, rem_d;
  logic              neg_q, neg_d;
  logic [CNT_W-1:0]  den_q, den_d;
  logic [CNT_W-1:0]  trial;
  logic              qbit;

  assign trial = {rem_q, mag_q[31]};
  assign qbit  = (trial >= den_q);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    mag_d  = mag_q;
    rem_d  = rem_q;
    neg_d  = neg_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 5'd31;
      neg_d  = req_i.num[31];
      mag_d  = req_i.num[31] ? 32'(-req_i.num) : 32'(req_i.num);
      rem_d  = '0;
      den_d  = req_i.den;
    end else if (busy_q) begin
      // shift in one dividend bit, subtract when it fits
      rem_d = qbit ? (CNT_W-1)'(trial - den_q) : trial[CNT_W-2:0];
      mag_d = {mag_q[30:0], qbit};
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = neg_q ? -$signed(mag_q) : $signed(mag_q);

endmodule
